// ===== sv/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// types, constants and microcode table of the deadband pid controller
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int STEP_W   = 3;
  localparam int ADDR_W   = 6;
  localparam int ADDR_LSB = 3;
  localparam int DATA_W   = 64;

  localparam int Q8       = 8;
  localparam int Q24      = 24;
  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 24;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int EDT_W    = 32;
  localparam int TERM_W   = 30;
  localparam int LIMIT_W  = 47;
  localparam int ACC_W    = 48;
  localparam int INTEG_W  = 49;
  localparam int ISUM_W   = 56;
  localparam int SUM_W    = 58;
  localparam int DRIVE_W  = 32;

  localparam logic [TERM_W-1:0]  TERM_LIMIT_RST  = '1;
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = '1;

  typedef struct packed {
    logic signed [15:0] measured;
    logic signed [15:0] setpoint;
    logic [15:0]        elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      in_deadband;
  } result_t;

  typedef enum logic [2:0] {
    REG_DEADBAND    = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_DERIV_GAIN  = 3'd3,
    REG_PROP_LIMIT  = 3'd4,
    REG_INTEG_LIMIT = 3'd5,
    REG_DERIV_LIMIT = 3'd6
  } reg_idx_t;

  // gains are held as magnitude and sign for the unsigned multiplier
  typedef struct packed {
    logic [15:0]         deadband;
    logic [16:0]         pg_mag;
    logic                pg_neg;
    logic [31:0]         ig_mag;
    logic                ig_neg;
    logic [16:0]         dg_mag;
    logic                dg_neg;
    logic [TERM_W-1:0]   prop_limit;
    logic [LIMIT_W-1:0]  integ_limit;
    logic [TERM_W-1:0]   deriv_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    MS_PROP  = 3'd0,
    MS_DERIV = 3'd1,
    MS_EDT   = 3'd2,
    MS_IHI   = 3'd3,
    MS_ILO   = 3'd4
  } mul_sel_t;

  typedef enum logic [2:0] {
    WB_NONE = 3'd0,
    WB_EDT  = 3'd1,
    WB_P    = 3'd2,
    WB_D    = 3'd3,
    WB_IHI  = 3'd4,
    WB_ILO  = 3'd5
  } wb_t;

  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_RUN  = 2'd1,
    FIN_DB   = 2'd2
  } fin_t;

  typedef struct packed {
    mul_sel_t          mul_sel;
    wb_t               wb;
    logic              diff_en;
    logic              mag_en;
    logic              pd_en;
    fin_t              fin;
    logic              jmp_db;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctl_t;

  typedef struct packed {
    logic en;
    ctl_t word;
  } dp_cmd_t;

  localparam logic [STEP_W-1:0] STEP_DB = 3'd7;

  // product issued in step k is written back in step k+1
  function automatic ctl_t ucode(logic [STEP_W-1:0] step);
    ctl_t w;
    w = '{mul_sel: MS_PROP, wb: WB_NONE, diff_en: 1'b0, mag_en: 1'b0, pd_en: 1'b0,
          fin: FIN_NONE, jmp_db: 1'b0, target: '0, last: 1'b0};
    case (step)
      3'd0: begin
        w.mul_sel = MS_EDT;
        w.diff_en = 1'b1;
        w.jmp_db  = 1'b1;
        w.target  = STEP_DB;
      end
      3'd1: begin
        w.wb      = WB_EDT;
        w.mul_sel = MS_PROP;
      end
      3'd2: begin
        w.wb      = WB_P;
        w.mag_en  = 1'b1;
        w.mul_sel = MS_DERIV;
      end
      3'd3: begin
        w.wb      = WB_D;
        w.mul_sel = MS_IHI;
      end
      3'd4: begin
        w.wb      = WB_IHI;
        w.mul_sel = MS_ILO;
        w.pd_en   = 1'b1;
      end
      3'd5: begin
        w.wb = WB_ILO;
      end
      3'd6: begin
        w.fin  = FIN_RUN;
        w.last = 1'b1;
      end
      3'd7: begin
        w.fin  = FIN_DB;
        w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/pdc_regs.sv =====
// ----------------------------------------------------------------------------
// pdc_regs
// configuration register file behind a 64-bit apb-style port
// ----------------------------------------------------------------------------
module pdc_regs import pdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [15:0]        deadband;
  logic [15:0]        prop_gain;
  logic [31:0]        integ_gain;
  logic [15:0]        deriv_gain;
  logic [TERM_W-1:0]  prop_limit;
  logic [LIMIT_W-1:0] integ_limit;
  logic [TERM_W-1:0]  deriv_limit;
  logic [16:0]        pg_mag;
  logic [31:0]        ig_mag;
  logic [16:0]        dg_mag;
  logic               wr;
  reg_idx_t           idx;

  function automatic logic [16:0] mag16(logic [15:0] v);
    logic signed [16:0] s;
    s = {v[15], v};
    return v[15] ? 17'(-s) : 17'(s);
  endfunction

  function automatic logic [31:0] mag32(logic [31:0] v);
    logic signed [32:0] s;
    s = {v[31], v};
    return v[31] ? 32'(-s) : 32'(s);
  endfunction

  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband    <= '0;
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      prop_limit  <= TERM_LIMIT_RST;
      integ_limit <= INTEG_LIMIT_RST;
      deriv_limit <= TERM_LIMIT_RST;
      pg_mag      <= '0;
      ig_mag      <= '0;
      dg_mag      <= '0;
    end else if (wr) begin
      case (idx)
        REG_DEADBAND:    deadband <= pwdata[15:0];
        REG_PROP_GAIN: begin
          prop_gain <= pwdata[15:0];
          pg_mag    <= mag16(pwdata[15:0]);
        end
        REG_INTEG_GAIN: begin
          integ_gain <= pwdata[31:0];
          ig_mag     <= mag32(pwdata[31:0]);
        end
        REG_DERIV_GAIN: begin
          deriv_gain <= pwdata[15:0];
          dg_mag     <= mag16(pwdata[15:0]);
        end
        REG_PROP_LIMIT:  prop_limit  <= pwdata[TERM_W-1:0];
        REG_INTEG_LIMIT: integ_limit <= pwdata[LIMIT_W-1:0];
        REG_DERIV_LIMIT: deriv_limit <= pwdata[TERM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEADBAND:    prdata = DATA_W'(deadband);
      REG_PROP_GAIN:   prdata = DATA_W'(prop_gain);
      REG_INTEG_GAIN:  prdata = DATA_W'(integ_gain);
      REG_DERIV_GAIN:  prdata = DATA_W'(deriv_gain);
      REG_PROP_LIMIT:  prdata = DATA_W'(prop_limit);
      REG_INTEG_LIMIT: prdata = DATA_W'(integ_limit);
      REG_DERIV_LIMIT: prdata = DATA_W'(deriv_limit);
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{deadband: deadband,
                 pg_mag: pg_mag, pg_neg: prop_gain[15],
                 ig_mag: ig_mag, ig_neg: integ_gain[31],
                 dg_mag: dg_mag, dg_neg: deriv_gain[15],
                 prop_limit: prop_limit,
                 integ_limit: integ_limit,
                 deriv_limit: deriv_limit};

endmodule

// ===== sv/pdc_seq.sv =====
// ----------------------------------------------------------------------------
// pdc_seq
// step counter and microcode rom that drive the datapath
// ----------------------------------------------------------------------------
module pdc_seq import pdc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    db_hit,
  input  logic    hold,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    finish
);

  logic [STEP_W-1:0] step;
  ctl_t              word;
  logic              advance;

  assign word    = ucode(step);
  // the last step waits while the result register is still held
  assign advance = busy && !(word.last && hold);
  assign finish  = advance && word.last;
  assign cmd     = '{en: advance, word: word};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (advance) begin
      if (word.last) begin
        busy <= 1'b0;
      end else if (word.jmp_db && db_hit) begin
        step <= word.target;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

// ===== sv/pdc_datapath.sv =====
// ----------------------------------------------------------------------------
// pdc_datapath
// shared 32x24 multiplier, term registers and controller state
// ----------------------------------------------------------------------------
module pdc_datapath import pdc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    start,
  input  sample_t sample,
  input  dp_cmd_t cmd,
  output logic    db_hit,
  output result_t res
);

  logic signed [16:0]        err_in;
  logic signed [16:0]        err;
  logic [16:0]               err_mag;
  logic [15:0]               dt;
  logic signed [17:0]        diff;
  logic [17:0]               dmag;
  logic                      dneg;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [PROD_W-1:0]         prod;
  logic signed [TERM_W:0]    p_term;
  logic signed [TERM_W:0]    d_term;
  logic signed [DRIVE_W-1:0] pd;
  logic signed [INTEG_W-1:0] integ;
  logic signed [INTEG_W-1:0] integ_sum;
  logic signed [INTEG_W-1:0] acc_ext;
  logic signed [INTEG_W-1:0] edt_ext;
  logic [ACC_W-1:0]          integ_mag;
  logic [ISUM_W-1:0]         isum;
  logic signed [ACC_W-1:0]   integral_acc;
  logic signed [ACC_W-1:0]   lim_ext;
  logic signed [16:0]        last_error;
  logic                      last_negative;
  logic                      i_neg;
  logic signed [SUM_W-1:0]   pd_ext;
  logic signed [SUM_W-1:0]   isum_ext;
  logic signed [SUM_W-1:0]   total;
  logic [SUM_W-DRIVE_W:0]    total_hi;
  logic signed [DRIVE_W-1:0] drive_sat;

  function automatic logic signed [TERM_W:0] clamp_term(logic [TERM_W-1:0] m, logic neg,
                                                         logic [TERM_W-1:0] lim);
    logic [TERM_W-1:0]      c;
    logic signed [TERM_W:0] s;
    c = (m > lim) ? lim : m;
    s = {1'b0, c};
    return neg ? -s : s;
  endfunction

  assign err_in = {sample.setpoint[15], sample.setpoint} - {sample.measured[15], sample.measured};
  assign db_hit = err_mag <= {1'b0, cfg.deadband};
  assign diff   = {err[16], err} - {last_error[16], last_error};

  always_ff @(posedge clk) begin
    if (start) begin
      err     <= err_in;
      err_mag <= err_in[16] ? 17'(-err_in) : 17'(err_in);
      dt      <= sample.elapsed_ms;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.word.mul_sel)
      MS_PROP: begin
        mul_a = MUL_A_W'(cfg.pg_mag);
        mul_b = MUL_B_W'(err_mag);
      end
      MS_DERIV: begin
        mul_a = MUL_A_W'(cfg.dg_mag);
        mul_b = MUL_B_W'(dmag);
      end
      MS_EDT: begin
        mul_a = MUL_A_W'(err_mag);
        mul_b = MUL_B_W'(dt);
      end
      MS_IHI: begin
        mul_a = cfg.ig_mag;
        mul_b = MUL_B_W'(integ_mag[ACC_W-1:Q24]);
      end
      MS_ILO: begin
        mul_a = cfg.ig_mag;
        mul_b = MUL_B_W'(integ_mag[Q24-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // integral update: add e*dt, cleared on a sign change of the error
  always_comb begin
    acc_ext   = {integral_acc[ACC_W-1], integral_acc};
    edt_ext   = INTEG_W'(prod[EDT_W-1:0]);
    integ_sum = err[16] ? acc_ext - edt_ext : acc_ext + edt_ext;
    lim_ext   = ACC_W'(cfg.integ_limit);
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.word.diff_en) begin
        dmag <= diff[17] ? 18'(-diff) : 18'(diff);
        dneg <= diff[17];
      end
      if (cmd.word.mag_en) begin
        integ_mag <= integ[INTEG_W-1] ? ACC_W'(-integ) : ACC_W'(integ);
      end
      if (cmd.word.pd_en) begin
        pd <= DRIVE_W'(p_term) + DRIVE_W'(d_term);
      end
      case (cmd.word.wb)
        WB_EDT: integ  <= (err[16] != last_negative) ? '0 : integ_sum;
        WB_P:   p_term <= clamp_term(prod[Q8+TERM_W-1:Q8], cfg.pg_neg ^ err[16],
                                     cfg.prop_limit);
        WB_D:   d_term <= clamp_term(prod[Q8+TERM_W-1:Q8], cfg.dg_neg ^ dneg,
                                     cfg.deriv_limit);
        WB_IHI: isum   <= ISUM_W'(prod);
        WB_ILO: isum   <= isum + ISUM_W'(prod[PROD_W-1:Q24]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc  <= '0;
      last_error    <= '0;
      last_negative <= 1'b0;
    end else if (cmd.en && cmd.word.fin == FIN_RUN) begin
      if (integ_mag > ACC_W'(cfg.integ_limit)) begin
        integral_acc <= integ[INTEG_W-1] ? -lim_ext : lim_ext;
      end else begin
        integral_acc <= integ[ACC_W-1:0];
      end
      last_error    <= err;
      last_negative <= err[16];
    end
  end

  always_comb begin
    i_neg     = cfg.ig_neg ^ integ[INTEG_W-1];
    pd_ext    = SUM_W'(pd);
    isum_ext  = SUM_W'(isum);
    total     = i_neg ? pd_ext - isum_ext : pd_ext + isum_ext;
    total_hi  = total[SUM_W-1:DRIVE_W-1];
    if ((&total_hi) || !(|total_hi)) begin
      drive_sat = total[DRIVE_W-1:0];
    end else if (total[SUM_W-1]) begin
      drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
    if (cmd.word.fin == FIN_DB) begin
      res = '{drive: '0, in_deadband: 1'b1};
    end else begin
      res = '{drive: drive_sat, in_deadband: 1'b0};
    end
  end

endmodule

// ===== sv/pid_deadband_clamped.sv =====
// ----------------------------------------------------------------------------
// pid_deadband_clamped
// fixed-point pid controller with deadband, clamped terms and anti-windup
// ----------------------------------------------------------------------------
// One request at a time: a request outside the deadband runs microcode
// steps 0 to 6 in order, as the single shared 32x24 multiplier forms the
// five products (e*dt, P, D and the two halves of the integral term) one
// after another; a request inside the deadband runs step 0 and then jumps
// to step 7. The next request is accepted at the same edge that the current
// one completes. The result sits in an output register; the final step
// waits only while that register still holds an untaken result.
// Configuration registers lie at byte addresses 8*i and take 64-bit data.
module pid_deadband_clamped import pdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  sample_t           sample,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  result_t res;
  logic    busy;
  logic    finish;
  logic    db_hit;
  logic    accept;
  logic    hold;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = busy && !finish;
  assign hold         = result_valid && result_stall;

  pdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pdc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .db_hit (db_hit),
    .hold   (hold),
    .cmd    (cmd),
    .busy   (busy),
    .finish (finish)
  );

  pdc_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .start  (accept),
    .sample (sample),
    .cmd    (cmd),
    .db_hit (db_hit),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result <= res;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !finish)
    else $error("request accepted but sequencer not running its first step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    hold |-> !finish)
    else $error("result register overwritten while held");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    finish |=> result_valid)
    else $error("completed request produced no result");

  a_deadband_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.in_deadband |-> result.drive == '0)
    else $error("nonzero drive inside deadband");

endmodule
